// ===== rtl/pmst_pkg.sv =====
package pmst_pkg;
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOCONN  = 2'd1,
        ST_DROPPED = 2'd2
    } t_status;
    localparam int unsigned TOTAL_BITS = 22;
    localparam int unsigned VCNT_BITS  = 7;
    localparam int unsigned VTX_BITS   = 6;
endpackage

// ===== rtl/prim_minimum_spanning_tree_core.sv =====
// Prim spanning tree engine. Edge loads (mode 0) may arrive back to back while the core is
// idle with no result pending; they go into a single-port-write, registered-read edge memory.
// A start item (mode 1) runs one scan of the stored edges per vertex added: each round
// reads every stored edge from the memory through the pipeline, then hands off the result.
// Visited marks are a 64-bit register cleared at the end of each run, and every run empties
// the edge store. One result per vertex is given, in join order; a disconnected graph or a
// bad root ends the run with status 1 and last set. The user must write the vertex count
// only while idle; the block itself does not enforce this.
module prim_minimum_spanning_tree_core #(
    parameter int unsigned MAX_VERTICES = 64,
    parameter int unsigned MAX_EDGES    = 256,
    parameter int unsigned WEIGHT_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pmst_pkg::VCNT_BITS-1:0]      i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_mode,
    input  logic [pmst_pkg::VTX_BITS-1:0]       i_vertex_a,
    input  logic [pmst_pkg::VTX_BITS-1:0]       i_vertex_b,
    input  logic signed [15:0]                  i_weight,
    input  logic [pmst_pkg::VTX_BITS-1:0]       i_start_vertex,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [pmst_pkg::VTX_BITS-1:0]       o_added_vertex,
    output logic [pmst_pkg::VTX_BITS-1:0]       o_parent_vertex,
    output logic signed [15:0]                  o_edge_weight,
    output logic signed [pmst_pkg::TOTAL_BITS-1:0] o_total_weight,
    output logic                                o_last,
    output logic [1:0]                          o_status
);
    import pmst_pkg::*;

    localparam int unsigned AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int unsigned CW = $clog2(MAX_EDGES + 1);
    localparam int unsigned EW = 2 * VTX_BITS + WEIGHT_BITS;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_EMIT, S_WAIT} t_state;

    t_state                  r_state;
    logic [VCNT_BITS-1:0]    r_vcount;
    logic [CW-1:0]           r_ecount;
    logic                    r_dropped;
    logic [63:0]             r_visited;
    logic [VCNT_BITS-1:0]    r_size;
    logic [TOTAL_BITS-1:0]   r_total;
    logic [CW-1:0]           r_rptr;
    logic                    r_rd_v;
    logic                    r_found;
    logic signed [WEIGHT_BITS-1:0] r_bw;
    logic [VTX_BITS-1:0]     r_bfrom, r_bto;
    logic                    r_ok2;
    logic [VCNT_BITS-1:0]    r_n;

    logic                    r_ovalid;
    logic [VTX_BITS-1:0]     r_oadd, r_opar;
    logic signed [15:0]      r_ow;
    logic [TOTAL_BITS-1:0]   r_otot;
    logic                    r_olast, r_oend;
    logic [1:0]              r_ostat;

    logic [VCNT_BITS-1:0]    n_use;
    logic                    acc;
    logic                    load_ok;
    logic [EW-1:0]           rdata;
    logic [VTX_BITS-1:0]     ea, eb, efrom, eto;
    logic signed [WEIGHT_BITS-1:0] ew;
    logic                    cand, better;
    logic [TOTAL_BITS-1:0]   n_total;

    always_comb begin
        if (r_vcount == '0) begin
            n_use = VCNT_BITS'(1);
        end else if (r_vcount > VCNT_BITS'(MAX_VERTICES)) begin
            n_use = VCNT_BITS'(MAX_VERTICES);
        end else begin
            n_use = r_vcount;
        end
    end

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign acc     = i_valid && o_ready;
    assign load_ok = ({1'b0, i_vertex_a} < n_use) && ({1'b0, i_vertex_b} < n_use)
                     && (r_ecount < CW'(MAX_EDGES));

    pmst_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edges (
        .i_clk   (i_clk),
        .i_we    (acc && !i_mode && load_ok),
        .i_waddr (r_ecount[AW-1:0]),
        .i_wdata ({i_vertex_a, i_vertex_b, i_weight[WEIGHT_BITS-1:0]}),
        .i_raddr (r_rptr[AW-1:0]),
        .o_rdata (rdata)
    );

    assign ea = rdata[EW-1 -: VTX_BITS];
    assign eb = rdata[WEIGHT_BITS +: VTX_BITS];
    assign ew = rdata[WEIGHT_BITS-1:0];

    always_comb begin
        cand  = 1'b0;
        efrom = ea;
        eto   = eb;
        if (({1'b0, ea} < r_n) && ({1'b0, eb} < r_n) && (ea != eb)) begin
            if (r_visited[ea] && !r_visited[eb]) begin
                cand = 1'b1;
            end else if (r_visited[eb] && !r_visited[ea]) begin
                cand  = 1'b1;
                efrom = eb;
                eto   = ea;
            end
        end
        better  = cand && (!r_found || (ew < r_bw) || ((ew == r_bw) && (efrom < r_bfrom)));
        n_total = r_total + TOTAL_BITS'(r_bw);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_vcount  <= VCNT_BITS'(64);
            r_ecount  <= '0;
            r_dropped <= 1'b0;
            r_visited <= '0;
            r_size    <= '0;
            r_total   <= '0;
            r_ovalid  <= 1'b0;
            r_rd_v    <= 1'b0;
            r_found   <= 1'b0;
            r_rptr    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_vcount <= i_cfg_wdata;
            end
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc && !i_mode) begin
                        if (load_ok) begin
                            r_ecount <= r_ecount + CW'(1);
                        end else begin
                            r_dropped <= 1'b1;
                        end
                    end else if (acc) begin
                        r_n      <= n_use;
                        r_ok2    <= r_dropped;
                        r_ovalid <= 1'b1;
                        r_oadd   <= i_start_vertex;
                        r_opar   <= i_start_vertex;
                        r_ow     <= '0;
                        r_otot   <= '0;
                        if ({1'b0, i_start_vertex} >= n_use || n_use == VCNT_BITS'(1)) begin
                            r_olast  <= 1'b1;
                            r_ostat  <= ({1'b0, i_start_vertex} >= n_use) ? ST_NOCONN
                                      : (r_dropped ? ST_DROPPED : ST_OK);
                            r_ecount <= '0;
                            r_dropped <= 1'b0;
                        end else begin
                            r_olast   <= 1'b0;
                            r_ostat   <= r_dropped ? ST_DROPPED : ST_OK;
                            r_visited <= 64'(1) << i_start_vertex;
                            r_size    <= VCNT_BITS'(1);
                            r_total   <= '0;
                            r_state   <= S_WAIT;
                        end
                    end
                end
                S_WAIT: begin
                    // start next scan once the previous result has left
                    if (!r_ovalid || i_ready) begin
                        r_found <= 1'b0;
                        r_rptr  <= '0;
                        r_rd_v  <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_rd_v && better) begin
                        r_found <= 1'b1;
                        r_bw    <= ew;
                        r_bfrom <= efrom;
                        r_bto   <= eto;
                    end
                    if (r_rptr < r_ecount) begin
                        r_rptr <= r_rptr + CW'(1);
                        r_rd_v <= 1'b1;
                    end else begin
                        // the final read is compared in this cycle
                        r_rd_v  <= 1'b0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    r_ovalid <= 1'b1;
                    if (!r_found) begin
                        r_oadd <= '0;
                        r_opar <= '0;
                        r_ow   <= '0;
                        r_otot <= r_total;
                        r_olast <= 1'b1;
                        r_ostat <= ST_NOCONN;
                    end else begin
                        r_oadd  <= r_bto;
                        r_opar  <= r_bfrom;
                        r_ow    <= 16'(r_bw);
                        r_otot  <= n_total;
                        r_olast <= (r_size + VCNT_BITS'(1)) == r_n;
                        r_ostat <= r_ok2 ? ST_DROPPED : ST_OK;
                    end
                    if (!r_found || (r_size + VCNT_BITS'(1)) == r_n) begin
                        r_visited <= '0;
                        r_total   <= '0;
                        r_size    <= '0;
                        r_ecount  <= '0;
                        r_dropped <= 1'b0;
                        r_state   <= S_IDLE;
                    end else begin
                        r_total <= n_total;
                        r_visited[r_bto] <= 1'b1;
                        r_size  <= r_size + VCNT_BITS'(1);
                        r_state <= S_WAIT;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_ovalid;
    assign o_added_vertex  = r_oadd;
    assign o_parent_vertex = r_opar;
    assign o_edge_weight   = r_ow;
    assign o_total_weight  = r_otot;
    assign o_last          = r_olast;
    assign o_status        = r_ostat;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> !r_ovalid) else $error("result overwritten");
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_visited == '0)) else $error("marks not cleared");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ecount <= CW'(MAX_EDGES)) else $error("edge count overflow");
endmodule

// ===== rtl/pmst_ram.sv =====
module pmst_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== tb/sv/prim_minimum_spanning_tree_core_test.sv =====
module prim_minimum_spanning_tree_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import pmst_pkg::*;

    localparam int EDGE_SLOTS = 256;
    localparam int VTX_LIMIT  = 64;
    localparam int SETTLE     = 12;

    typedef struct {
        logic [5:0]         added;
        logic [5:0]         parent;
        logic signed [15:0] weight;
        logic signed [21:0] total;
        logic               last;
        t_status            status;
    } t_tree_step;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [6:0]         i_cfg_wdata;
    logic               i_valid;
    logic               o_ready;
    logic               i_mode;
    logic [5:0]         i_vertex_a;
    logic [5:0]         i_vertex_b;
    logic signed [15:0] i_weight;
    logic [5:0]         i_start_vertex;
    logic               o_valid;
    logic               i_ready;
    logic [5:0]         o_added_vertex;
    logic [5:0]         o_parent_vertex;
    logic signed [15:0] o_edge_weight;
    logic signed [21:0] o_total_weight;
    logic               o_last;
    logic [1:0]         o_status;

    // predictor state
    logic [5:0]         edge_from [EDGE_SLOTS];
    logic [5:0]         edge_to [EDGE_SLOTS];
    logic signed [15:0] edge_wt [EDGE_SLOTS];
    int                 stored_edges;
    bit                 edges_dropped;
    logic [6:0]         vertex_cfg;

    t_tree_step joins_q[$];
    int         mismatches;
    bit         no_idle;
    int         stall_left;

    prim_minimum_spanning_tree_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_vertex_a     (i_vertex_a),
        .i_vertex_b     (i_vertex_b),
        .i_weight       (i_weight),
        .i_start_vertex (i_start_vertex),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_added_vertex (o_added_vertex),
        .o_parent_vertex(o_parent_vertex),
        .o_edge_weight  (o_edge_weight),
        .o_total_weight (o_total_weight),
        .o_last         (o_last),
        .o_status       (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    function automatic int vertices_active();
        if (vertex_cfg < 1) return 1;
        if (vertex_cfg > VTX_LIMIT) return VTX_LIMIT;
        return vertex_cfg;
    endfunction

    function automatic void push_join(logic [5:0] v, logic [5:0] p, logic signed [15:0] w,
                                      logic signed [21:0] t, logic l, t_status s);
        t_tree_step r;
        r.added = v; r.parent = p; r.weight = w; r.total = t; r.last = l; r.status = s;
        joins_q = {joins_q, r};
    endfunction

    function automatic void clear_graph();
        stored_edges  = 0;
        edges_dropped = 0;
    endfunction

    // Work out the join order of one run from the given root.
    function automatic void predict_prim_run(logic [5:0] root);
        int                 n;
        int                 sz;
        int                 a;
        int                 b;
        int                 f;
        int                 t;
        int                 bf;
        int                 bt;
        bit                 seen [VTX_LIMIT];
        bit                 found;
        logic signed [15:0] bw;
        logic signed [21:0] tot;
        t_status            okst;
        n    = vertices_active();
        okst = edges_dropped ? ST_DROPPED : ST_OK;
        if (root >= n) begin
            push_join(root, root, 0, 0, 1'b1, ST_NOCONN);
            clear_graph();
            return;
        end
        foreach (seen[i]) seen[i] = 0;
        seen[root] = 1;
        sz  = 1;
        tot = 0;
        push_join(root, root, 0, 0, n == 1, okst);
        while (sz < n) begin
            found = 0; bw = 0; bf = 0; bt = 0;
            for (int e = 0; e < stored_edges; e++) begin
                a = edge_from[e];
                b = edge_to[e];
                if (a >= n || b >= n || a == b) continue;
                if (seen[a] && !seen[b]) begin
                    f = a; t = b;
                end else if (seen[b] && !seen[a]) begin
                    f = b; t = a;
                end else begin
                    continue;
                end
                if (!found || edge_wt[e] < bw || (edge_wt[e] == bw && f < bf)) begin
                    found = 1; bw = edge_wt[e]; bf = f; bt = t;
                end
            end
            if (!found) begin
                push_join(0, 0, 0, tot, 1'b1, ST_NOCONN);
                clear_graph();
                return;
            end
            tot      = tot + 22'(bw);
            seen[bt] = 1;
            sz++;
            push_join(bt[5:0], bf[5:0], bw, tot, sz == n, okst);
        end
        clear_graph();
    endfunction

    function automatic void predict_item(logic mode, logic [5:0] a, logic [5:0] b,
                                         logic signed [15:0] w, logic [5:0] root);
        int n;
        n = vertices_active();
        if (mode) begin
            predict_prim_run(root);
        end else if (a >= n || b >= n || stored_edges >= EDGE_SLOTS) begin
            edges_dropped = 1;
        end else begin
            edge_from[stored_edges] = a;
            edge_to[stored_edges]   = b;
            edge_wt[stored_edges]   = w;
            stored_edges++;
        end
    endfunction

    // Called at a rising edge; returns at the edge of the transfer or after the gap.
    task automatic send_item(logic mode, logic [5:0] a, logic [5:0] b,
                             logic signed [15:0] w, logic [5:0] root);
        int r;
        int gap;
        i_valid        <= 1'b1;
        i_mode         <= mode;
        i_vertex_a     <= a;
        i_vertex_b     <= b;
        i_weight       <= w;
        i_start_vertex <= root;
        do @(posedge i_clk); while (!o_ready);
        predict_item(mode, a, b, w, root);
        r   = $urandom_range(0, 19);
        gap = (no_idle || r < 12) ? 0 : (r < 18) ? $urandom_range(1, 3) : $urandom_range(6, 40);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic load_edge(logic [5:0] a, logic [5:0] b, logic signed [15:0] w);
        send_item(1'b0, a, b, w, 6'($urandom));
    endtask

    task automatic start_run(logic [5:0] root);
        send_item(1'b1, 6'($urandom), 6'($urandom), 16'($urandom), root);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (joins_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_vertex_count(logic [6:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        vertex_cfg  = value;
    endtask

    // Receiver stalls: mostly ready, some short holds, a few long ones.
    always @(posedge i_clk) begin
        if (!i_rst_n || no_idle) begin
            i_ready    <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 9) < 3) begin
            i_ready    <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                       : $urandom_range(0, 2);
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_tree_step exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (joins_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: vertex %0d parent %0d", o_added_vertex,
                             o_parent_vertex);
            end else begin
                exp_r = joins_q.pop_front();
                if (o_added_vertex !== exp_r.added || o_parent_vertex !== exp_r.parent ||
                    o_edge_weight !== exp_r.weight || o_total_weight !== exp_r.total ||
                    o_last !== exp_r.last || o_status !== exp_r.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp v%0d p%0d w%0d t%0d l%0b s%0d got v%0d p%0d w%0d t%0d l%0b s%0d",
                                 exp_r.added, exp_r.parent, exp_r.weight, exp_r.total,
                                 exp_r.last, exp_r.status, o_added_vertex, o_parent_vertex,
                                 o_edge_weight, o_total_weight, o_last, o_status);
                end
            end
        end
    end

    task automatic test_small_graph();
        set_vertex_count(7'd4);
        load_edge(6'd0, 6'd1, 16'sh7FFF);
        load_edge(6'd1, 6'd2, -16'sd32768);
        load_edge(6'd2, 6'd2, -16'sd5);         // self loop, never chosen
        load_edge(6'd3, 6'd0, 16'sd3);
        load_edge(6'd0, 6'd3, 16'sd3);          // tie on weight and source
        load_edge(6'd2, 6'd3, 16'sd3);          // same weight, chosen before the others are candidates
        load_edge(6'd5, 6'd1, 16'sd1);          // out of range, dropped
        start_run(6'd2);
    endtask

    task automatic test_bad_root();
        load_edge(6'd0, 6'd1, 16'sd9);
        start_run(6'd63);
        start_run(6'd4);
    endtask

    task automatic test_disconnected();
        set_vertex_count(7'd3);
        load_edge(6'd0, 6'd1, 16'sd100);
        start_run(6'd1);
    endtask

    task automatic test_count_extremes();
        set_vertex_count(7'd0);                 // saturates to one vertex
        start_run(6'd0);
        set_vertex_count(7'd1);
        load_edge(6'd0, 6'd0, 16'sd1);
        start_run(6'd0);
        set_vertex_count(7'd127);               // saturates to the maximum
        load_edge(6'd63, 6'd62, -16'sd1);
        start_run(6'd63);
    endtask

    // Fill the store past capacity: excess loads are dropped.
    task automatic test_store_full();
        set_vertex_count(7'd64);
        no_idle = 1;
        for (int i = 0; i < EDGE_SLOTS + 4; i++)
            load_edge(6'($urandom), 6'($urandom), 16'($urandom));
        no_idle = 0;
        start_run(6'($urandom));
    endtask

    task automatic random_graph(int n, bit burst);
        int  extra;
        int  v;
        logic [5:0] p;
        logic signed [15:0] w;
        no_idle = burst;
        if (vertex_cfg != n) set_vertex_count(7'(n));
        extra = $urandom_range(0, n);
        for (v = 1; v < n; v++) begin
            p = 6'($urandom_range(0, v - 1));
            w = ($urandom_range(0, 1) != 0) ? 16'(int'($urandom_range(0, 3)) - 1)
                                            : 16'($urandom);
            if ($urandom_range(0, 19) == 0) continue;       // leave a hole now and then
            if ($urandom_range(0, 1) != 0) load_edge(p, 6'(v), w);
            else load_edge(6'(v), p, w);
        end
        for (int i = 0; i < extra; i++) begin
            if (n < VTX_LIMIT && $urandom_range(0, 7) == 0)
                load_edge(6'($urandom_range(n, 63)), 6'($urandom_range(0, n - 1)),
                          16'($urandom));
            else
                load_edge(6'($urandom_range(0, n - 1)), 6'($urandom_range(0, n - 1)),
                          16'(int'($urandom_range(0, 7)) - 4));
        end
        if (n < VTX_LIMIT && $urandom_range(0, 9) == 0) start_run(6'($urandom_range(n, 63)));
        else start_run(6'($urandom_range(0, n - 1)));
        no_idle = 0;
    endtask

    task automatic test_random();
        int runs;
        runs = 0;
        while (runs < 6) begin
            random_graph(($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
                                                     : $urandom_range(2, 8),
                         $urandom_range(0, 4) == 0);
            runs++;
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        i_valid        = 1'b0;
        i_mode         = 1'b0;
        i_vertex_a     = '0;
        i_vertex_b     = '0;
        i_weight       = '0;
        i_start_vertex = '0;
        i_ready        = 1'b1;
        mismatches     = 0;
        no_idle        = 0;
        stall_left     = 0;
        vertex_cfg     = 7'd64;
        clear_graph();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_small_graph();
        test_bad_root();
        test_disconnected();
        test_count_extremes();
        test_store_full();
        test_random();

        wait_idle();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
